### rtl/wrm_pkg.sv
`default_nettype none
package wrm_pkg;

  // Field widths
  localparam int unsigned TIME_W   = 40;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned RATE_W   = 48;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned USEC_W   = 20;
  localparam int unsigned SCALED_W = COUNT_W + USEC_W;
  localparam int unsigned STEP_W   = $clog2(RATE_W);

  // Default ring size and register reset
  localparam int unsigned RING_DEPTH   = 64;
  localparam logic [COUNT_W-1:0] WINDOW_RESET = COUNT_W'(1000000);

  // Microseconds per second, the rate scale
  localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);

  typedef enum logic {
    ACT_RECORD = 1'b0,
    ACT_QUERY  = 1'b1
  } action_e;

  typedef struct packed {
    logic               action;
    logic [TIME_W-1:0]  time_us;
    logic [COUNT_W-1:0] tick_count;
  } in_item_t;

  typedef struct packed {
    logic [RATE_W-1:0] window_rate;
    logic [RATE_W-1:0] global_rate;
    logic              saturated;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]  time_us;
    logic [COUNT_W-1:0] tick_count;
  } ring_entry_t;

  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  den;
  } div_cmd_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [RATE_W-1:0] rate;
  } div_rsp_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_MUL,
    DIV_CHK,
    DIV_RUN
  } div_state_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_LATEST,
    SEQ_GLOB,
    SEQ_WALK,
    SEQ_WIN,
    SEQ_DONE
  } seq_state_e;

endpackage
`default_nettype wire

### rtl/wrm_ring.sv
`default_nettype none
module wrm_ring import wrm_pkg::*; #(
  parameter int unsigned RingDepth = RING_DEPTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         rec_i,
  input  wire ring_entry_t                  rec_entry_i,
  input  wire logic [$clog2(RingDepth)-1:0] raddr_i,
  output      ring_entry_t                  rd_entry_o,
  output      logic [$clog2(RingDepth)-1:0] latest_o
);

  localparam int unsigned IdxW = $clog2(RingDepth);

  ring_entry_t     mem [RingDepth];
  ring_entry_t     rd_q;
  logic            rd_valid_q;
  logic [IdxW-1:0] latest_q, latest_d;
  logic            any_q;
  logic            wrapped_q, wrapped_d;

  // Advance the latest index; the first tick lands on entry 0
  always_comb begin
    latest_d  = latest_q;
    wrapped_d = wrapped_q;
    if (any_q) begin
      if (latest_q == IdxW'(RingDepth - 1)) begin
        latest_d  = '0;
        wrapped_d = 1'b1;
      end else begin
        latest_d = latest_q + 1'b1;
      end
    end else begin
      latest_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latest_q  <= '0;
      any_q     <= 1'b0;
      wrapped_q <= 1'b0;
    end else if (rec_i) begin
      latest_q  <= latest_d;
      any_q     <= 1'b1;
      wrapped_q <= wrapped_d;
    end
  end

  // Store the tick record
  always_ff @(posedge clk_i) begin
    if (rec_i) begin
      mem[latest_d] <= rec_entry_i;
    end
  end

  // Read one entry a cycle; entries not yet written since reset read as zero
  always_ff @(posedge clk_i) begin
    rd_q       <= mem[raddr_i];
    rd_valid_q <= any_q && (wrapped_q || (raddr_i <= latest_q));
  end

  assign rd_entry_o = rd_valid_q ? rd_q : '0;
  assign latest_o   = latest_q;

endmodule
`default_nettype wire

### rtl/wrm_div.sv
`default_nettype none
module wrm_div import wrm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_cmd_t cmd_i,
  output      div_rsp_t rsp_o
);

  div_state_e          state_q, state_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [TIME_W-1:0]   den_q, den_d;
  logic [SCALED_W-1:0] scaled_q, scaled_d;
  logic [TIME_W-1:0]   rem_q, rem_d;
  logic [RATE_W-1:0]   quo_q, quo_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                done_q, done_d;
  logic                sat_q, sat_d;
  logic [TIME_W:0]     trial;
  logic [TIME_W-1:0]   scaled_hi;

  assign trial     = {rem_q, quo_q[RATE_W-1]};
  assign scaled_hi = TIME_W'(scaled_q[SCALED_W-1:COUNT_W]);

  // Scale by 1e6, check for overflow or a zero divisor, then one restoring step a cycle
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    den_d    = den_q;
    scaled_d = scaled_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    step_d   = step_q;
    done_d   = 1'b0;
    sat_d    = sat_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (cmd_i.start) begin
          count_d = cmd_i.count;
          den_d   = cmd_i.den;
          state_d = DIV_MUL;
        end
      end
      DIV_MUL: begin
        scaled_d = SCALED_W'(count_q) * SCALED_W'(USEC_PER_SEC);
        state_d  = DIV_CHK;
      end
      DIV_CHK: begin
        // quotient of 2^48 or more, or a zero divisor: saturate
        if (scaled_hi >= den_q) begin
          quo_d   = '1;
          sat_d   = 1'b1;
          done_d  = 1'b1;
          state_d = DIV_IDLE;
        end else begin
          rem_d   = scaled_hi;
          quo_d   = {scaled_q[COUNT_W-1:0], {FRAC_W{1'b0}}};
          step_d  = '0;
          sat_d   = 1'b0;
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (trial >= {1'b0, den_q}) begin
          rem_d = TIME_W'(trial - {1'b0, den_q});
          quo_d = {quo_q[RATE_W-2:0], 1'b1};
        end else begin
          rem_d = trial[TIME_W-1:0];
          quo_d = {quo_q[RATE_W-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(RATE_W - 1)) begin
          done_d  = 1'b1;
          state_d = DIV_IDLE;
        end
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q  <= count_d;
    den_q    <= den_d;
    scaled_q <= scaled_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    step_q   <= step_d;
    sat_q    <= sat_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sat  = sat_q;
  assign rsp_o.rate = quo_q;

endmodule
`default_nettype wire

### rtl/windowed_rate_meter.sv
// Windowed event rate meter.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries requests: a
// record request stores a (time, cumulative count) tick in the ring, a query
// request returns one result on the output channel (out_valid_o /
// out_stall_i / out_data_o) with the windowed rate, the rate since start and
// a saturation flag. Rates are events per second with 16 fraction bits.
// cfg_we_i / cfg_wdata_i write the window length in microseconds; write it
// only while no query is in flight.
// A record gives no result. A query reads the latest tick, runs the global
// division, walks back one ring entry per cycle (1 to RingDepth entries)
// and runs the window division; each division runs in the shared divider,
// which stops early when it saturates. An empty ring skips both divisions
// and the walk, and a stale latest tick skips the walk and the window
// division.
// The block takes one request at a time and stalls its input until the
// query result sits in the output register; a result that is held by
// out_stall_i leaves room for the next request, which stalls only once its
// own result is ready. Reset empties the ring at once (written entries are
// tracked by a fill index) and sets the window to one second.
`default_nettype none
module windowed_rate_meter import wrm_pkg::*; #(
  parameter int unsigned RingDepth = RING_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire in_item_t           in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      out_item_t          out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [COUNT_W-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW = $clog2(RingDepth);

  seq_state_e         state_q, state_d;
  logic [COUNT_W-1:0] window_q;
  logic [TIME_W-1:0]  now_q, now_d;
  logic [TIME_W-1:0]  lt_q, lt_d;
  logic [COUNT_W-1:0] lc_q, lc_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [TIME_W-1:0]  pt_q, pt_d;
  logic [COUNT_W-1:0] pc_q, pc_d;
  logic [RATE_W-1:0]  grate_q, grate_d;
  logic [RATE_W-1:0]  wrate_q, wrate_d;
  logic               sat_q, sat_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_data_q, out_data_d;

  logic               accept;
  logic               rec;
  logic [IdxW-1:0]    raddr;
  logic [IdxW-1:0]    latest;
  logic [IdxW-1:0]    prev_idx;
  ring_entry_t        rd_entry;
  div_cmd_t           div_cmd;
  div_rsp_t           div_rsp;
  logic [TIME_W-1:0]  window_ext;
  logic               stale;
  logic               in_window;
  logic               out_free;

  assign window_ext = TIME_W'(window_q);
  assign accept     = in_valid_i && (state_q == SEQ_IDLE);
  assign in_stall_o = (state_q != SEQ_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Step back one entry, wrapping around the ring
  assign prev_idx = (idx_q == '0) ? IdxW'(RingDepth - 1) : idx_q - 1'b1;

  // Latest tick older than the window; checked against the latched latest tick
  assign stale = (now_q > lt_q) && ((now_q - lt_q) > window_ext);

  // Entry under the walk still lies inside the window
  assign in_window = (now_q < rd_entry.time_us) ||
                     ((now_q - rd_entry.time_us) < window_ext);

  // Hold the window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  wrm_ring #(
    .RingDepth (RingDepth)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (rec),
    .rec_entry_i ({in_data_i.time_us, in_data_i.tick_count}),
    .raddr_i     (raddr),
    .rd_entry_o  (rd_entry),
    .latest_o    (latest)
  );

  wrm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .rsp_o  (div_rsp)
  );

  // Sequence one request: store a record, or read latest, global division, walk, window division
  always_comb begin
    state_d       = state_q;
    now_d         = now_q;
    lt_d          = lt_q;
    lc_d          = lc_q;
    idx_d         = idx_q;
    pt_d          = pt_q;
    pc_d          = pc_q;
    grate_d       = grate_q;
    wrate_d       = wrate_q;
    sat_d         = sat_q;
    rec           = 1'b0;
    raddr         = latest;
    div_cmd.start = 1'b0;
    div_cmd.count = lc_q;
    div_cmd.den   = now_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_data_d    = out_data_q;

    unique case (state_q)
      SEQ_IDLE: begin
        if (accept) begin
          if (in_data_i.action == ACT_QUERY) begin
            now_d   = in_data_i.time_us;
            state_d = SEQ_LATEST;
          end else begin
            rec = 1'b1;
          end
        end
      end
      SEQ_LATEST: begin
        lt_d = rd_entry.time_us;
        lc_d = rd_entry.tick_count;
        if ((latest == '0) && (rd_entry.time_us == '0)) begin
          // empty ring: all zero
          grate_d = '0;
          wrate_d = '0;
          sat_d   = 1'b0;
          state_d = SEQ_DONE;
        end else begin
          div_cmd.start = 1'b1;
          div_cmd.count = rd_entry.tick_count;
          div_cmd.den   = now_q;
          state_d       = SEQ_GLOB;
        end
      end
      SEQ_GLOB: begin
        idx_d = latest;
        if (div_rsp.done) begin
          grate_d = div_rsp.rate;
          sat_d   = div_rsp.sat;
          if (stale) begin
            wrate_d = '0;
            state_d = SEQ_DONE;
          end else begin
            idx_d   = (latest == '0) ? IdxW'(RingDepth - 1) : latest - 1'b1;
            raddr   = idx_d;
            state_d = SEQ_WALK;
          end
        end
      end
      SEQ_WALK: begin
        // read data holds the entry at idx_q
        if (idx_q == latest) begin
          // came back around: base is the entry after latest
          div_cmd.start = 1'b1;
          div_cmd.count = lc_q - pc_q;
          div_cmd.den   = (lt_q > pt_q) ? lt_q - pt_q : '0;
          state_d       = SEQ_WIN;
        end else if ((idx_q == '0) && (rd_entry.time_us == '0)) begin
          // reached the empty start of the ring
          div_cmd.start = 1'b1;
          div_cmd.count = lc_q - rd_entry.tick_count;
          div_cmd.den   = lt_q;
          state_d       = SEQ_WIN;
        end else if (!in_window) begin
          div_cmd.start = 1'b1;
          div_cmd.count = lc_q - rd_entry.tick_count;
          div_cmd.den   = window_ext;
          state_d       = SEQ_WIN;
        end else begin
          pt_d  = rd_entry.time_us;
          pc_d  = rd_entry.tick_count;
          idx_d = prev_idx;
          raddr = prev_idx;
        end
      end
      SEQ_WIN: begin
        if (div_rsp.done) begin
          wrate_d = div_rsp.rate;
          sat_d   = sat_q || div_rsp.sat;
          state_d = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_data_d.window_rate = wrate_q;
          out_data_d.global_rate = grate_q;
          out_data_d.saturated   = sat_q;
          state_d                = SEQ_IDLE;
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    lt_q       <= lt_d;
    lc_q       <= lc_d;
    idx_q      <= idx_d;
    pt_q       <= pt_d;
    pc_q       <= pc_d;
    grate_q    <= grate_d;
    wrate_q    <= wrate_d;
    sat_q      <= sat_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

### sim/tb_windowed_rate_meter.sv
`timescale 1ns / 1ps

module tb_windowed_rate_meter;
  import wrm_pkg::*;

  // Tracks the tick ring and predicts the rates of each query request
  class rate_scoreboard;
    bit [TIME_W-1:0]  stamp_ring[RING_DEPTH];
    bit [COUNT_W-1:0] total_ring[RING_DEPTH];
    int unsigned      newest;
    bit               seen_any;
    bit [COUNT_W-1:0] window_len;
    out_item_t        rates_due_q[$];
    int unsigned      mismatches;
    int unsigned      results_checked;

    function new();
      foreach (stamp_ring[k]) begin
        stamp_ring[k] = '0;
        total_ring[k] = '0;
      end
      newest          = 0;
      seen_any        = 1'b0;
      window_len      = WINDOW_RESET;
      mismatches      = 0;
      results_checked = 0;
    endfunction

    function void set_window(bit [COUNT_W-1:0] len);
      window_len = len;
    endfunction

    function int unsigned pending();
      return rates_due_q.size();
    endfunction

    function int unsigned step_back(int unsigned idx);
      return (idx == 0) ? RING_DEPTH - 1 : idx - 1;
    endfunction

    // floor(count * 1e6 * 2^16 / span), saturating on zero span or overflow
    function bit [RATE_W-1:0] scaled_rate(bit [COUNT_W-1:0] count, bit [63:0] span,
                                          inout bit sat);
      bit [63:0] prod;
      bit [63:0] quot;
      bit [63:0] rem;
      if (span == 0) begin
        sat = 1'b1;
        return {RATE_W{1'b1}};
      end
      prod = 64'(count) * 64'(USEC_PER_SEC);
      quot = prod / span;
      rem  = prod % span;
      if (quot > 64'hFFFF_FFFF) begin
        sat = 1'b1;
        return {RATE_W{1'b1}};
      end
      return RATE_W'((quot << FRAC_W) | ((rem << FRAC_W) / span));
    endfunction

    function out_item_t predict_rates(bit [TIME_W-1:0] now);
      int unsigned     pos;
      int unsigned     base;
      bit [TIME_W-1:0] last_t;
      bit [63:0]       span;
      bit              sat;
      out_item_t       res;
      res    = '0;
      sat    = 1'b0;
      pos    = newest;
      last_t = stamp_ring[pos];
      // Empty ring gives all zero
      if (!(pos == 0 && last_t == 0)) begin
        res.global_rate = scaled_rate(total_ring[pos], 64'(now), sat);
        // Skip the window rate when the latest tick is stale
        if (!(now > last_t && (now - last_t) > window_len)) begin
          base = step_back(pos);
          while ((now < stamp_ring[base] || 64'(now - stamp_ring[base]) < 64'(window_len))
                 && !(base == 0 && stamp_ring[base] == 0) && base != pos)
            base = step_back(base);
          if (base == 0 && stamp_ring[base] == 0) begin
            span = 64'(last_t);
          end else if (base == pos) begin
            base = (base + 1) % RING_DEPTH;
            span = (last_t > stamp_ring[base]) ? 64'(last_t - stamp_ring[base]) : 64'd0;
          end else begin
            span = 64'(window_len);
          end
          res.window_rate = scaled_rate(total_ring[pos] - total_ring[base], span, sat);
        end
      end
      res.saturated = sat;
      return res;
    endfunction

    // Store a tick or queue the rates a query will return
    function void note_request(in_item_t req);
      if (req.action == ACT_RECORD) begin
        newest   = seen_any ? (newest + 1) % RING_DEPTH : 0;
        seen_any = 1'b1;
        stamp_ring[newest] = req.time_us;
        total_ring[newest] = req.tick_count;
      end else begin
        rates_due_q = {rates_due_q, predict_rates(req.time_us)};
      end
    endfunction

    function void check_rates(out_item_t got);
      out_item_t want;
      results_checked++;
      if (rates_due_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with no query pending: window %h global %h sat %b",
                   $time, got.window_rate, got.global_rate, got.saturated);
        mismatches++;
        return;
      end
      want = rates_due_q.pop_front();
      if (got.window_rate !== want.window_rate || got.global_rate !== want.global_rate ||
          got.saturated !== want.saturated) begin
        if (mismatches < 10)
          $display("%0t: window exp %h got %h, global exp %h got %h, sat exp %b got %b",
                   $time, want.window_rate, got.window_rate, want.global_rate,
                   got.global_rate, want.saturated, got.saturated);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  in_item_t           in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_item_t          out_data_o;
  logic               cfg_we_i;
  logic [COUNT_W-1:0] cfg_wdata_i;

  rate_scoreboard sb = new();
  bit             calm;
  bit             held_off;
  bit [63:0]      clock_now;
  bit [63:0]      last_tick;
  bit [COUNT_W-1:0] count_now;

  windowed_rate_meter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watch both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_request(in_data_i);
      if (out_valid_o && !out_stall_i)
        sb.check_rates(out_data_o);
    end
  end

  function automatic int unsigned pick_gap();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic in_item_t req_of(action_e act, logic [TIME_W-1:0] t,
                                      logic [COUNT_W-1:0] c);
    in_item_t req;
    req.action     = act;
    req.time_us    = t;
    req.tick_count = c;
    return req;
  endfunction

  // Offer one request and hold it until taken
  task automatic send_req(input in_item_t req);
    int unsigned idle;
    idle = pick_gap();
    if (idle > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (idle - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid, wait for every pending result, then let a record settle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_window(input logic [COUNT_W-1:0] len);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_window(len);
  endtask

  // Mostly ordered ticks and nearby queries, with some noise
  task automatic run_phase(input logic [COUNT_W-1:0] len, input int unsigned items,
                           input bit quiet);
    in_item_t    req;
    bit [63:0]   win;
    bit [63:0]   step;
    int unsigned pick;
    drain();
    write_window(len);
    calm = quiet;
    win  = 64'(len);
    repeat (items) begin
      req.tick_count = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        req.action  = 1'($urandom_range(0, 1));
        req.time_us = ($urandom_range(0, 3) == 0) ? '0 : TIME_W'({$urandom(), $urandom()});
        if (req.action == ACT_RECORD)
          last_tick = 64'(req.time_us);
      end else if (pick < 42) begin
        req.action = ACT_QUERY;
        case ($urandom_range(0, 5))
          0: step = 0;
          1: step = (win * $urandom_range(0, 100)) / 100;
          2: step = win;
          3: step = win + 1;
          4: step = win + $urandom_range(2, 100000);
          default: step = -64'($urandom_range(1, 1000));
        endcase
        req.time_us = TIME_W'(last_tick + step);
      end else begin
        req.action = ACT_RECORD;
        case ($urandom_range(0, 3))
          0: step = $urandom_range(0, 3);
          1: step = win / 64 + $urandom_range(0, 7);
          2: step = win / $urandom_range(1, 8);
          default: step = win + $urandom_range(0, 1000);
        endcase
        clock_now = (clock_now + step) & 64'hFF_FFFF_FFFF;
        count_now += ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 5000);
        req.time_us    = TIME_W'(clock_now);
        req.tick_count = count_now;
        last_tick      = clock_now;
      end
      send_req(req);
    end
  endtask

  // Result side: random stalls, plus one long hold-off to back up the block
  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    held_off    = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && sb.results_checked >= 40) begin
        held_off = 1'b1;
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (999) @(negedge clk_i);
      end
      hold = pick_gap();
      if (hold > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (hold - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    calm        = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty ring, zero-time tick, saturation, stale tick, extremes
    send_req(req_of(ACT_QUERY, 40'd5, 32'd0));
    send_req(req_of(ACT_RECORD, 40'd0, 32'd7));
    send_req(req_of(ACT_QUERY, 40'd100, 32'd0));
    send_req(req_of(ACT_RECORD, 40'd1000, 32'd50));
    send_req(req_of(ACT_QUERY, 40'd1500, 32'd0));
    send_req(req_of(ACT_QUERY, 40'd0, 32'd0));
    send_req(req_of(ACT_RECORD, 40'd2000, 32'hFFFF_FFFF));
    send_req(req_of(ACT_QUERY, 40'd2000, 32'd0));
    send_req(req_of(ACT_RECORD, 40'd2_500_000, 32'd10));
    send_req(req_of(ACT_QUERY, 40'd2_500_000, 32'd0));
    send_req(req_of(ACT_QUERY, 40'd3_500_001, 32'd0));
    send_req(req_of(ACT_QUERY, 40'd3_500_000, 32'd0));
    send_req(req_of(ACT_QUERY, 40'd1, 32'd0));
    send_req(req_of(ACT_RECORD, 40'hFF_FFFF_FFFF, 32'd123));
    send_req(req_of(ACT_QUERY, 40'hFF_FFFF_FFFF, 32'd0));
    send_req(req_of(ACT_RECORD, 40'd10, 32'd200));
    send_req(req_of(ACT_QUERY, 40'd10, 32'd0));
    send_req(req_of(ACT_QUERY, 40'd20, 32'hFFFF_FFFF));
    clock_now = 64'd10;
    last_tick = 64'd10;
    count_now = 32'd200;

    // Random phases over several window lengths, extremes included
    run_phase(32'd1, 85, 1'b0);
    run_phase(32'hFFFF_FFFF, 85, 1'b1);
    run_phase(32'd1000, 85, 1'b0);
    run_phase($urandom_range(2, 32'hFFFF_FFFE), 85, 1'b0);
    run_phase(WINDOW_RESET, 85, 1'b1);

    drain();
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
rtl/wrm_pkg.sv
rtl/wrm_ring.sv
rtl/wrm_div.sv
rtl/windowed_rate_meter.sv
sim/tb_windowed_rate_meter.sv
